>>> sv/rv32ic_pkg.sv
// rv32ic_pkg: mnemonic codes, decode result type and opcode tables for the
// rv32ic instruction decoder; no dependencies
package rv32ic_pkg;

  typedef logic [5:0] mnem_t;

  localparam mnem_t MN_UNK   = 6'd0;
  localparam mnem_t MN_LUI   = 6'd1;
  localparam mnem_t MN_AUIPC = 6'd2;
  localparam mnem_t MN_JAL   = 6'd3;
  localparam mnem_t MN_JALR  = 6'd4;
  localparam mnem_t MN_BEQ   = 6'd5;
  localparam mnem_t MN_BNE   = 6'd6;
  localparam mnem_t MN_BLT   = 6'd7;
  localparam mnem_t MN_BGE   = 6'd8;
  localparam mnem_t MN_BLTU  = 6'd9;
  localparam mnem_t MN_BGEU  = 6'd10;
  localparam mnem_t MN_LB    = 6'd11;
  localparam mnem_t MN_LH    = 6'd12;
  localparam mnem_t MN_LW    = 6'd13;
  localparam mnem_t MN_LBU   = 6'd14;
  localparam mnem_t MN_LHU   = 6'd15;
  localparam mnem_t MN_SB    = 6'd16;
  localparam mnem_t MN_SH    = 6'd17;
  localparam mnem_t MN_SW    = 6'd18;
  localparam mnem_t MN_ADDI  = 6'd19;
  localparam mnem_t MN_SLTI  = 6'd20;
  localparam mnem_t MN_SLTIU = 6'd21;
  localparam mnem_t MN_XORI  = 6'd22;
  localparam mnem_t MN_ORI   = 6'd23;
  localparam mnem_t MN_ANDI  = 6'd24;
  localparam mnem_t MN_SLLI  = 6'd25;
  localparam mnem_t MN_SRLI  = 6'd26;
  localparam mnem_t MN_SRAI  = 6'd27;
  localparam mnem_t MN_ADD   = 6'd28;
  localparam mnem_t MN_SUB   = 6'd29;
  localparam mnem_t MN_SLL   = 6'd30;
  localparam mnem_t MN_SLT   = 6'd31;
  localparam mnem_t MN_SLTU  = 6'd32;
  localparam mnem_t MN_XOR   = 6'd33;
  localparam mnem_t MN_SRL   = 6'd34;
  localparam mnem_t MN_SRA   = 6'd35;
  localparam mnem_t MN_OR    = 6'd36;
  localparam mnem_t MN_AND   = 6'd37;
  localparam mnem_t MN_ECALL = 6'd38;

  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_JAL    = 7'h6F;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_SYSTEM = 7'h73;

  localparam logic [1:0] QUAD_MEM   = 2'd0;
  localparam logic [1:0] QUAD_ARITH = 2'd1;
  localparam logic [1:0] QUAD_REG   = 2'd2;
  localparam logic [1:0] QUAD_FULL  = 2'd3;
  localparam logic [6:0] F7_ALT     = 7'h20;

  typedef struct packed {
    mnem_t        mn;
    logic [4:0]   rd;
    logic [4:0]   rs1;
    logic [4:0]   rs2;
    logic [31:0]  imm;
    logic         br;
  } dec_t;

  function automatic mnem_t branch_mn(input logic [2:0] f3);
    mnem_t m;
    unique case (f3)
      3'd0:    m = MN_BEQ;
      3'd1:    m = MN_BNE;
      3'd4:    m = MN_BLT;
      3'd5:    m = MN_BGE;
      3'd6:    m = MN_BLTU;
      3'd7:    m = MN_BGEU;
      default: m = MN_UNK;
    endcase
    return m;
  endfunction

  function automatic mnem_t load_mn(input logic [2:0] f3);
    mnem_t m;
    unique case (f3)
      3'd0:    m = MN_LB;
      3'd1:    m = MN_LH;
      3'd2:    m = MN_LW;
      3'd4:    m = MN_LBU;
      3'd5:    m = MN_LHU;
      default: m = MN_UNK;
    endcase
    return m;
  endfunction

  function automatic mnem_t store_mn(input logic [2:0] f3);
    mnem_t m;
    unique case (f3)
      3'd0:    m = MN_SB;
      3'd1:    m = MN_SH;
      3'd2:    m = MN_SW;
      default: m = MN_UNK;
    endcase
    return m;
  endfunction

  function automatic mnem_t opimm_mn(input logic [2:0] f3);
    mnem_t m;
    unique case (f3)
      3'd0:    m = MN_ADDI;
      3'd2:    m = MN_SLTI;
      3'd3:    m = MN_SLTIU;
      3'd4:    m = MN_XORI;
      3'd6:    m = MN_ORI;
      3'd7:    m = MN_ANDI;
      default: m = MN_UNK;
    endcase
    return m;
  endfunction

  function automatic mnem_t op_mn(input logic [2:0] f3);
    mnem_t m;
    unique case (f3)
      3'd0:    m = MN_ADD;
      3'd1:    m = MN_SLL;
      3'd2:    m = MN_SLT;
      3'd3:    m = MN_SLTU;
      3'd4:    m = MN_XOR;
      3'd5:    m = MN_SRL;
      3'd6:    m = MN_OR;
      default: m = MN_AND;
    endcase
    return m;
  endfunction

  function automatic mnem_t carith_mn(input logic [1:0] sel);
    mnem_t m;
    unique case (sel)
      2'd0:    m = MN_SUB;
      2'd1:    m = MN_XOR;
      2'd2:    m = MN_OR;
      default: m = MN_AND;
    endcase
    return m;
  endfunction

endpackage

>>> sv/rv32ic_instruction_decoder_unit.sv
// rv32ic_instruction_decoder_unit: rv32ic decoder with program counter,
// input register, single-pass decode and output register; uses rv32ic_pkg
// an input beat goes through the input register, then the output register
// throughput: one instruction per cycle while out_tready allows, set by the
// single decode pass between the input register and the output register
// reset (synchronous, active low) clears the program counter and all valids
module rv32ic_instruction_decoder_unit
  import rv32ic_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [31:0]  cfg_wr_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // instr_word
  output logic         out_tvalid,
  input  logic         out_tready,
  // instr_address, mnemonic, dest_reg, src1_reg, src2_reg, immediate,
  // target_address, zero pad
  output logic [119:0] out_tdata,
  output logic [1:0]   out_tuser   // is_compressed, is_branch_or_jump
);

  logic [31:0]  pc_r, pc_nxt;
  logic         s1_valid_r, s1_valid_nxt;
  logic [31:0]  s1_word_r;
  logic [31:0]  s1_addr_r;
  logic         out_valid_r, out_valid_nxt;
  logic [119:0] out_data_r;
  logic [1:0]   out_user_r;

  logic  in_beat;
  logic  s1_adv;
  logic  comp;
  dec_t  d32, d16, dsel;
  logic [31:0] target;

  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_beat   = in_tvalid && in_tready;

  // program counter
  always_comb begin
    pc_nxt = pc_r;
    if (cfg_wr_en) begin
      pc_nxt = cfg_wr_data;
    end else if (in_beat) begin
      pc_nxt = (in_tdata[1:0] != QUAD_FULL) ? pc_r + 32'd2 : pc_r + 32'd4;
    end
  end

  // 32-bit decode
  always_comb begin
    logic [6:0]  op;
    logic [4:0]  rd, rs1, rs2;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] imm_i, imm_s, imm_b, imm_u, imm_j;
    logic [31:0] w;
    w     = s1_word_r;
    op    = w[6:0];
    rd    = w[11:7];
    f3    = w[14:12];
    rs1   = w[19:15];
    rs2   = w[24:20];
    f7    = w[31:25];
    imm_i = {{20{w[31]}}, w[31:20]};
    imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
    imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    imm_u = {w[31:12], 12'd0};
    imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
    d32   = '0;
    unique case (op)
      OP_LUI:    d32 = '{MN_LUI, rd, 5'd0, 5'd0, imm_u, 1'b0};
      OP_AUIPC:  d32 = '{MN_AUIPC, rd, 5'd0, 5'd0, imm_u, 1'b0};
      OP_JAL:    d32 = '{MN_JAL, rd, 5'd0, 5'd0, imm_j, 1'b1};
      OP_JALR:   d32 = '{MN_JALR, rd, rs1, 5'd0, imm_i, 1'b0};
      OP_BRANCH: d32 = '{branch_mn(f3), 5'd0, rs1, rs2, imm_b, 1'b1};
      OP_LOAD:   d32 = '{load_mn(f3), rd, rs1, 5'd0, imm_i, 1'b0};
      OP_STORE:  d32 = '{store_mn(f3), 5'd0, rs1, rs2, imm_s, 1'b0};
      OP_IMM: begin
        if (f3 == 3'd1) begin
          d32 = '{MN_SLLI, rd, rs1, 5'd0, {27'd0, rs2}, 1'b0};
        end else if (f3 == 3'd5) begin
          d32 = '{(f7 == 7'd0) ? MN_SRLI : MN_SRAI, rd, rs1, 5'd0, {27'd0, rs2}, 1'b0};
        end else begin
          d32 = '{opimm_mn(f3), rd, rs1, 5'd0, imm_i, 1'b0};
        end
      end
      OP_REG: begin
        d32 = '{op_mn(f3), rd, rs1, rs2, 32'd0, 1'b0};
        if (f7 == F7_ALT && f3 == 3'd0) d32.mn = MN_SUB;
        if (f7 == F7_ALT && f3 == 3'd5) d32.mn = MN_SRA;
      end
      OP_SYSTEM: d32 = '{MN_ECALL, 5'd0, 5'd0, 5'd0, 32'd0, 1'b0};
      default:   d32 = '0;
    endcase
  end

  // 16-bit decode
  always_comb begin
    logic [15:0] h;
    logic [2:0]  f3;
    logic        b12;
    logic [4:0]  rl, rr, rp1, rp2;
    logic [31:0] imm6, uw, ij, ib, lui_imm;
    h       = s1_word_r[15:0];
    f3      = h[15:13];
    b12     = h[12];
    rl      = h[11:7];
    rr      = h[6:2];
    rp1     = {2'b01, h[9:7]};
    rp2     = {2'b01, h[4:2]};
    imm6    = {{26{h[12]}}, h[12], h[6:2]};
    uw      = {25'd0, h[5], h[12:10], h[6], 2'b00};
    ij      = {{20{h[12]}}, h[12], h[8], h[10:9], h[6], h[7], h[2], h[11], h[5:3], 1'b0};
    ib      = {{23{h[12]}}, h[12], h[6:5], h[2], h[11:10], h[4:3], 1'b0};
    lui_imm = {{14{h[12]}}, h[12], h[6:2], 12'd0};
    d16     = '0;
    unique case (h[1:0])
      QUAD_MEM: begin
        if (f3 == 3'd2) d16 = '{MN_LW, rp2, rp1, 5'd0, uw, 1'b0};
        if (f3 == 3'd6) d16 = '{MN_SW, 5'd0, rp1, rp2, uw, 1'b0};
      end
      QUAD_ARITH: begin
        unique case (f3)
          3'd0: d16 = '{MN_ADDI, rl, rl, 5'd0, imm6, 1'b0};
          3'd1: d16 = '{MN_JAL, 5'd1, 5'd0, 5'd0, ij, 1'b1};
          3'd3: begin
            if (rl != 5'd2) d16 = '{MN_LUI, rl, 5'd0, 5'd0, lui_imm, 1'b0};
          end
          3'd4: begin
            if (h[11:10] == 2'd2) begin
              d16 = '{MN_ANDI, rp1, rp1, 5'd0, imm6, 1'b0};
            end else if (!b12) begin
              unique case (h[11:10])
                2'd0:    d16 = '{MN_SRLI, rp1, rp1, 5'd0, {27'd0, rr}, 1'b0};
                2'd1:    d16 = '{MN_SRAI, rp1, rp1, 5'd0, {27'd0, rr}, 1'b0};
                default: d16 = '{carith_mn(h[6:5]), rp1, rp1, rp2, 32'd0, 1'b0};
              endcase
            end
          end
          3'd6:    d16 = '{MN_BEQ, 5'd0, rp1, 5'd0, ib, 1'b1};
          3'd7:    d16 = '{MN_BNE, 5'd0, rp1, 5'd0, ib, 1'b1};
          default: d16 = '0;
        endcase
      end
      QUAD_REG: begin
        if (f3 == 3'd0 && !b12) begin
          d16 = '{MN_SLLI, rl, rl, 5'd0, {27'd0, rr}, 1'b0};
        end else if (f3 == 3'd4) begin
          if (rr != 5'd0) begin
            d16 = '{MN_ADD, rl, b12 ? rl : 5'd0, rr, 32'd0, 1'b0};
          end else if (rl != 5'd0) begin
            d16 = '{MN_JALR, b12 ? 5'd1 : 5'd0, rl, 5'd0, 32'd0, 1'b0};
          end
        end
      end
      default: d16 = '0;
    endcase
  end

  // select, clear unknowns, form target
  always_comb begin
    comp = (s1_word_r[1:0] != QUAD_FULL);
    dsel = comp ? d16 : d32;
    if (dsel.mn == MN_UNK) dsel = '0;
    target = dsel.br ? s1_addr_r + dsel.imm : 32'd0;
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_beat) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= 32'd0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_word_r <= in_tdata;
      s1_addr_r <= pc_r;
    end
    if (s1_adv && s1_valid_r) begin
      out_data_r <= {3'd0, target, dsel.imm, dsel.rs2, dsel.rs1, dsel.rd, dsel.mn,
                     s1_addr_r};
      out_user_r <= {dsel.br, comp};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

>>> tb/tb_rv32ic_instruction_decoder_unit.sv
// tb_rv32ic_instruction_decoder_unit: self-checking bench for the rv32ic decoder, a directed
// table then random instruction words under random stalls, checked against a local decoder
// and program counter model; depends on rv32ic_pkg and rv32ic_instruction_decoder_unit
module tb_rv32ic_instruction_decoder_unit
  import rv32ic_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 500_000;
  localparam int PHASES = 6;
  localparam int WORDS_PER_PHASE = 205;
  localparam int DIR_ROWS = 26;

  localparam dec_t BLANK = '0;

  typedef struct packed {
    logic [31:0] addr;
    dec_t        d;
    logic        comp;
    logic [31:0] target;
  } decoded_t;

  typedef struct packed {
    logic [31:0] word;
    logic        typed;
    dec_t        want;
  } row_t;

  logic         clk;
  logic         rst_n = 1'b0;
  logic         cfg_wr_en = 1'b0;
  logic [31:0]  cfg_wr_data = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [31:0]  in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [119:0] out_tdata;
  logic [1:0]   out_tuser;

  decoded_t    decodes_due[$];
  logic [31:0] pc_model = '0;
  int          mismatches = 0;
  int          cycles = 0;
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b0;

  mnem_t branch_kind [8] = '{MN_BEQ, MN_BNE, MN_UNK, MN_UNK, MN_BLT, MN_BGE, MN_BLTU, MN_BGEU};
  mnem_t load_kind [8] = '{MN_LB, MN_LH, MN_LW, MN_UNK, MN_LBU, MN_LHU, MN_UNK, MN_UNK};
  mnem_t store_kind [8] = '{MN_SB, MN_SH, MN_SW, MN_UNK, MN_UNK, MN_UNK, MN_UNK, MN_UNK};
  mnem_t opimm_kind [8] = '{MN_ADDI, MN_UNK, MN_SLTI, MN_SLTIU, MN_XORI, MN_UNK, MN_ORI,
                            MN_ANDI};
  mnem_t reg_kind [8] = '{MN_ADD, MN_SLL, MN_SLT, MN_SLTU, MN_XOR, MN_SRL, MN_OR, MN_AND};
  mnem_t carith_kind [4] = '{MN_SUB, MN_XOR, MN_OR, MN_AND};
  logic [6:0] base_ops [10] = '{OP_LUI, OP_AUIPC, OP_JAL, OP_JALR, OP_BRANCH, OP_LOAD,
                                OP_STORE, OP_IMM, OP_REG, OP_SYSTEM};

  row_t dir_rows [DIR_ROWS] = '{
    '{32'h0000_0000, 1'b1, BLANK},
    '{32'hFFFF_FFFF, 1'b1, BLANK},
    '{32'h0000_0073, 1'b1, '{MN_ECALL, 5'd0, 5'd0, 5'd0, 32'h0, 1'b0}},
    '{32'hFFFF_FFF3, 1'b1, '{MN_ECALL, 5'd0, 5'd0, 5'd0, 32'h0, 1'b0}},
    '{32'hFFFF_FFB7, 1'b1, '{MN_LUI, 5'd31, 5'd0, 5'd0, 32'hFFFF_F000, 1'b0}},
    '{32'h0000_0017, 1'b1, '{MN_AUIPC, 5'd0, 5'd0, 5'd0, 32'h0, 1'b0}},
    '{32'h8000_006F, 1'b1, '{MN_JAL, 5'd0, 5'd0, 5'd0, 32'hFFF0_0000, 1'b1}},
    '{32'h7FFF_F0EF, 1'b0, BLANK},
    '{32'h8000_A0E7, 1'b0, BLANK},
    '{32'hFE00_0EE3, 1'b0, BLANK},
    '{32'h0000_2063, 1'b1, BLANK},
    '{32'hFFFF_F3E3, 1'b0, BLANK},
    '{32'h0000_3003, 1'b1, BLANK},
    '{32'hFFF4_C283, 1'b0, BLANK},
    '{32'hFE11_2E23, 1'b0, BLANK},
    '{32'h0000_7023, 1'b1, BLANK},
    '{32'hFFF0_9093, 1'b0, BLANK},
    '{32'h0200_5013, 1'b0, BLANK},
    '{32'h4020_D0B3, 1'b0, BLANK},
    '{32'h4000_0033, 1'b0, BLANK},
    '{32'hFFFF_5FFC, 1'b0, BLANK},
    '{32'h0000_3FFD, 1'b0, BLANK},
    '{32'h0000_6105, 1'b1, BLANK},
    '{32'h0000_9002, 1'b1, BLANK},
    '{32'h0000_8002, 1'b1, BLANK},
    '{32'hABCD_9001, 1'b1, BLANK}
  };

  rv32ic_instruction_decoder_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),     // instr_word
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    // instr_address, mnemonic, dest_reg, src1_reg, src2_reg, immediate,
    // target_address, zero pad
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)     // is_compressed, is_branch_or_jump
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic dec_t fields(input mnem_t mn, input logic [4:0] rd, input logic [4:0] rs1,
                                  input logic [4:0] rs2, input logic [31:0] imm,
                                  input logic br);
    dec_t d;
    d = '{mn, rd, rs1, rs2, imm, br};
    if (mn == MN_UNK) d = '0;
    return d;
  endfunction

  function automatic dec_t decode_full(input logic [31:0] w);
    logic [4:0]  rd, rs1, rs2;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] imm_i, imm_s, imm_b, imm_u, imm_j;
    mnem_t       mn;
    rd = w[11:7];
    f3 = w[14:12];
    rs1 = w[19:15];
    rs2 = w[24:20];
    f7 = w[31:25];
    imm_i = {{20{w[31]}}, w[31:20]};
    imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
    imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    imm_u = {w[31:12], 12'd0};
    imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
    case (w[6:0])
      OP_LUI:    return fields(MN_LUI, rd, 5'd0, 5'd0, imm_u, 1'b0);
      OP_AUIPC:  return fields(MN_AUIPC, rd, 5'd0, 5'd0, imm_u, 1'b0);
      OP_JAL:    return fields(MN_JAL, rd, 5'd0, 5'd0, imm_j, 1'b1);
      OP_JALR:   return fields(MN_JALR, rd, rs1, 5'd0, imm_i, 1'b0);
      OP_BRANCH: return fields(branch_kind[f3], 5'd0, rs1, rs2, imm_b, 1'b1);
      OP_LOAD:   return fields(load_kind[f3], rd, rs1, 5'd0, imm_i, 1'b0);
      OP_STORE:  return fields(store_kind[f3], 5'd0, rs1, rs2, imm_s, 1'b0);
      OP_IMM: begin
        // shift amount sits in the rs2 field
        if (f3 == 3'd1) return fields(MN_SLLI, rd, rs1, 5'd0, {27'd0, rs2}, 1'b0);
        if (f3 == 3'd5) begin
          mn = (f7 == 7'd0) ? MN_SRLI : MN_SRAI;
          return fields(mn, rd, rs1, 5'd0, {27'd0, rs2}, 1'b0);
        end
        return fields(opimm_kind[f3], rd, rs1, 5'd0, imm_i, 1'b0);
      end
      OP_REG: begin
        mn = reg_kind[f3];
        if (f7 == F7_ALT && f3 == 3'd0) mn = MN_SUB;
        if (f7 == F7_ALT && f3 == 3'd5) mn = MN_SRA;
        return fields(mn, rd, rs1, rs2, 32'd0, 1'b0);
      end
      OP_SYSTEM: return fields(MN_ECALL, 5'd0, 5'd0, 5'd0, 32'd0, 1'b0);
      default:   return BLANK;
    endcase
  endfunction

  function automatic dec_t decode_half(input logic [15:0] h);
    logic [2:0]  f3;
    logic [4:0]  rl, rr, rp1, rp2;
    logic [31:0] imm6, uw, ij, ib;
    f3 = h[15:13];
    rl = h[11:7];
    rr = h[6:2];
    rp1 = {2'b01, h[9:7]};
    rp2 = {2'b01, h[4:2]};
    imm6 = {{27{h[12]}}, h[6:2]};
    uw = {25'd0, h[5], h[12:10], h[6], 2'b00};
    ij = {{21{h[12]}}, h[8], h[10:9], h[6], h[7], h[2], h[11], h[5:3], 1'b0};
    ib = {{24{h[12]}}, h[6:5], h[2], h[11:10], h[4:3], 1'b0};
    case (h[1:0])
      QUAD_MEM: begin
        if (f3 == 3'd2) return fields(MN_LW, rp2, rp1, 5'd0, uw, 1'b0);
        if (f3 == 3'd6) return fields(MN_SW, 5'd0, rp1, rp2, uw, 1'b0);
      end
      QUAD_ARITH: begin
        case (f3)
          3'd0: return fields(MN_ADDI, rl, rl, 5'd0, imm6, 1'b0);
          3'd1: return fields(MN_JAL, 5'd1, 5'd0, 5'd0, ij, 1'b1);
          3'd3: begin
            // rd x2 would be the stack adjust form, not covered
            if (rl != 5'd2) return fields(MN_LUI, rl, 5'd0, 5'd0, imm6 << 12, 1'b0);
          end
          3'd4: begin
            if (h[11:10] == 2'd2) return fields(MN_ANDI, rp1, rp1, 5'd0, imm6, 1'b0);
            if (!h[12]) begin
              if (h[11:10] == 2'd0) return fields(MN_SRLI, rp1, rp1, 5'd0, {27'd0, rr}, 1'b0);
              if (h[11:10] == 2'd1) return fields(MN_SRAI, rp1, rp1, 5'd0, {27'd0, rr}, 1'b0);
              return fields(carith_kind[h[6:5]], rp1, rp1, rp2, 32'd0, 1'b0);
            end
          end
          3'd6: return fields(MN_BEQ, 5'd0, rp1, 5'd0, ib, 1'b1);
          3'd7: return fields(MN_BNE, 5'd0, rp1, 5'd0, ib, 1'b1);
          default: ;
        endcase
      end
      QUAD_REG: begin
        if (f3 == 3'd0 && !h[12]) return fields(MN_SLLI, rl, rl, 5'd0, {27'd0, rr}, 1'b0);
        if (f3 == 3'd4) begin
          // mv / jr without bit 12, add / jalr with it
          if (rr != 5'd0) return fields(MN_ADD, rl, h[12] ? rl : 5'd0, rr, 32'd0, 1'b0);
          if (rl != 5'd0) return fields(MN_JALR, h[12] ? 5'd1 : 5'd0, rl, 5'd0, 32'd0, 1'b0);
        end
      end
      default: ;
    endcase
    return BLANK;
  endfunction

  function automatic decoded_t decode_instr(input logic [31:0] w, input logic [31:0] addr);
    decoded_t r;
    r.addr = addr;
    r.comp = (w[1:0] != QUAD_FULL);
    r.d = r.comp ? decode_half(w[15:0]) : decode_full(w);
    r.target = r.d.br ? addr + r.d.imm : 32'd0;
    return r;
  endfunction

  function automatic logic [31:0] rand_word();
    logic [31:0] w;
    int          pick;
    w = $urandom;
    pick = $urandom_range(0, 9);
    if (pick >= 6) begin
      w[1:0] = 2'($urandom_range(0, 2));
      if (pick == 9) w[6:2] = 5'd0;
    end else if (pick >= 1) begin
      w[6:0] = base_ops[4'($urandom_range(0, 9))];
      case ($urandom_range(0, 3))
        0:       w[31:25] = 7'd0;
        1:       w[31:25] = F7_ALT;
        default: ;
      endcase
    end
    return w;
  endfunction

  task automatic push_word(input logic [31:0] w, input logic typed, input dec_t want);
    int       gap;
    decoded_t e;
    gap = in_calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    e = decode_instr(w, pc_model);
    if (typed) begin
      e.d = want;
      e.target = want.br ? pc_model + want.imm : 32'd0;
    end
    pc_model = pc_model + (e.comp ? 32'd2 : 32'd4);
    decodes_due.push_back(e);
    in_tvalid <= 1'b1;
    in_tdata <= w;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (decodes_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_start(input logic [31:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    pc_model = v;
  endtask

  task automatic compare(input string what, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h got %h", $time, what, want, got);
      mismatches++;
    end
  endtask

  initial begin : drive
    logic [31:0] starts [PHASES];
    starts = '{32'hFFFF_FFFA, 32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0,
               32'h7FFF_FFFE};
    starts[4] = $urandom;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    pc_model = '0;
    for (int i = 0; i < DIR_ROWS; i++) begin
      push_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);
    end
    settle();
    for (int p = 0; p < PHASES; p++) begin
      load_start(starts[p]);
      for (int k = 0; k < WORDS_PER_PHASE; k++) begin
        if (k % 50 == 0) begin
          in_calm = ($urandom_range(0, 3) == 0);
          out_calm = ($urandom_range(0, 3) == 0);
        end
        push_word(rand_word(), 1'b0, BLANK);
      end
      settle();
    end
    if (mismatches == 0) begin
      $display("tb_rv32ic_instruction_decoder_unit: PASS");
    end else begin
      $display("tb_rv32ic_instruction_decoder_unit: FAIL");
    end
    $finish;
  end

  initial begin : sink
    int gap;
    forever begin
      gap = out_calm ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  always @(posedge clk) begin : check
    decoded_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (decodes_due.size() == 0) begin
        $display("%0t: result beat with nothing expected, expected none got %h %h",
                 $time, out_tdata, out_tuser);
        mismatches++;
      end else begin
        e = decodes_due.pop_front();
        compare("instr_address", e.addr, out_tdata[31:0]);
        compare("mnemonic", 32'(e.d.mn), 32'(out_tdata[37:32]));
        compare("dest_reg", 32'(e.d.rd), 32'(out_tdata[42:38]));
        compare("src1_reg", 32'(e.d.rs1), 32'(out_tdata[47:43]));
        compare("src2_reg", 32'(e.d.rs2), 32'(out_tdata[52:48]));
        compare("immediate", e.d.imm, out_tdata[84:53]);
        compare("target_address", e.target, out_tdata[116:85]);
        compare("is_compressed", 32'(e.comp), 32'(out_tuser[0]));
        compare("is_branch_or_jump", 32'(e.d.br), 32'(out_tuser[1]));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_rv32ic_instruction_decoder_unit: FAIL");
      $finish;
    end
  end

endmodule
